// File: rtl/assert_macros.svh
// Assertion macros used by bpfr_window of the byte pattern find/replace core.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while out of reset
`define ASSERT_ON(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/bpfr_pkg.sv
// Package for the byte pattern find/replace core: request types, config
// bundle, register map codes and default sizing. No dependencies.
`timescale 1ns / 1ps

package bpfr_pkg;

    // Default window depth (longest pattern supported)
    localparam int BPFR_MAX_PATTERN = 4;

    // APB address width: four 32-bit registers
    localparam int BPFR_ADDR_W = 4;

    // Register index codes (paddr[3:2])
    localparam logic [1:0] REG_PATTERN_LEN    = 2'd0;
    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd1;
    localparam logic [1:0] REG_REPLACE_BYTES  = 2'd2;
    localparam logic [1:0] REG_REPLACE_ENABLE = 2'd3;

    // Input request payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in;
    } t_in_item;

    // Result request payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_match;
        logic       last_out;
    } t_out_item;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [2:0]  pattern_len;
        logic [31:0] pattern_bytes;
        logic [31:0] replace_bytes;
        logic        replace_enable;
    } t_cfg;

endpackage

// File: rtl/bpfr_cfg.sv
// APB register block of the byte pattern find/replace core.
// Depends on bpfr_pkg for the register codes and the config bundle type.
`timescale 1ns / 1ps

module bpfr_cfg import bpfr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [BPFR_ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PATTERN_LEN:    r_cfg.pattern_len    <= pwdata[2:0];
                REG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= pwdata;
                REG_REPLACE_BYTES:  r_cfg.replace_bytes  <= pwdata;
                REG_REPLACE_ENABLE: r_cfg.replace_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_PATTERN_LEN:    prdata = 32'(r_cfg.pattern_len);
            REG_PATTERN_BYTES:  prdata = r_cfg.pattern_bytes;
            REG_REPLACE_BYTES:  prdata = r_cfg.replace_bytes;
            REG_REPLACE_ENABLE: prdata = 32'(r_cfg.replace_enable);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: rtl/bpfr_window.sv
// Match window of the byte pattern find/replace core: insert, parallel
// compare, replace/mark, shift-out, and the flush/drain sequencing.
// Depends on bpfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpfr_window import bpfr_pkg::*; #(
    parameter int MAX_PATTERN = BPFR_MAX_PATTERN
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_item_valid,
    input  t_in_item  i_item,
    input  logic      i_res_ready,
    output logic      o_item_take,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam int FW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Byte k of a 32-bit register; lanes past the fourth read as zero
    function automatic logic [7:0] lane_byte(input logic [31:0] word, input int k);
        logic [7:0] b;
        b = 8'd0;
        if (k < 4) b = word[8*k +: 8];
        return b;
    endfunction

    logic [7:0]             r_data [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_mark;
    logic [FW-1:0]          r_fill;
    logic                   r_drain;
    logic                   r_last;

    logic [7:0]             n_data [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] n_mark;
    logic [FW-1:0]          n_fill;
    logic                   n_drain;
    logic                   n_last;

    logic [7:0]             ins_data [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ins_mark;
    logic [FW-1:0]          ins_fill;
    logic [IW-1:0]          ins_pos;
    logic [7:0]             ev_data [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ev_mark;
    logic [FW-1:0]          len;
    logic [FW-1:0]          sh_fill;
    logic                   go;
    logic                   run;
    logic                   hit;
    logic                   more;

    // Effective pattern length, saturated to the window depth
    always_comb begin
        if (32'(i_cfg.pattern_len) > MAX_PATTERN) len = FW'(MAX_PATTERN);
        else                                      len = FW'(i_cfg.pattern_len);
    end

    // Step a byte: take a new request, or keep draining the held bytes
    assign o_item_take = !r_drain && i_item_valid && i_res_ready;
    assign go          = r_drain ? i_res_ready : o_item_take;

    always_comb begin
        // insert the new byte behind the held ones
        ins_data = r_data;
        ins_mark = r_mark;
        ins_fill = r_fill;
        n_last   = r_last;
        if (r_fill >= FW'(MAX_PATTERN)) ins_pos = IW'(MAX_PATTERN - 1);
        else                            ins_pos = r_fill[IW-1:0];
        if (!r_drain) begin
            ins_data[ins_pos] = i_item.data_byte;
            ins_mark[ins_pos] = 1'b0;
            ins_fill          = FW'(ins_pos) + FW'(1);
            n_last            = i_item.last_in;
        end

        run = (ins_fill != '0) && (n_last || ins_fill >= len);

        // compare the window start against the pattern
        hit = (len != '0) && (ins_fill >= len);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (FW'(k) < len && ins_data[k] != lane_byte(i_cfg.pattern_bytes, k)) begin
                hit = 1'b0;
            end
        end

        // rewrite or mark the matched bytes
        ev_data = ins_data;
        ev_mark = ins_mark;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (hit && FW'(k) < len) begin
                if (i_cfg.replace_enable) ev_data[k] = lane_byte(i_cfg.replace_bytes, k);
                else                      ev_mark[k] = 1'b1;
            end
        end

        // oldest byte leaves, the rest move down
        sh_fill = ins_fill - FW'(1);
        more    = (sh_fill != '0) && (n_last || sh_fill >= len);

        if (run) begin
            for (int k = 0; k < MAX_PATTERN; k++) n_data[k] = 8'd0;
            for (int k = 0; k < MAX_PATTERN - 1; k++) n_data[k] = ev_data[k + 1];
            n_mark  = ev_mark >> 1;
            n_fill  = sh_fill;
            n_drain = more;
        end else begin
            n_data  = ins_data;
            n_mark  = ins_mark;
            n_fill  = ins_fill;
            n_drain = 1'b0;
        end
    end

    // Result for this step
    assign o_res_valid    = go && run;
    assign o_res.out_byte = ev_data[0];
    assign o_res.in_match = ev_mark[0];
    assign o_res.last_out = n_last && !more;

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) r_data[k] <= 8'd0;
            r_mark  <= '0;
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_last  <= 1'b0;
        end else if (go) begin
            r_data  <= n_data;
            r_mark  <= n_mark;
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_last  <= n_last;
        end
    end

    // Between steps at most MAX_PATTERN-1 bytes are held
    `ASSERT_ON(a_fill_bound, r_fill <= FW'(MAX_PATTERN - 1), "window fill out of range")
    // Draining always has a byte left to emit
    `ASSERT_ON(a_drain_nonempty, r_drain |-> (r_fill != '0), "drain with empty window")
    // The final byte of a stream leaves the window empty
    `ASSERT_ON(a_flush_empties, (o_res_valid && o_res.last_out) |=> ((r_fill == '0) && !r_drain), "flush left bytes in window")
    // Reset clears the sequencing state
    `ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!r_drain && (r_fill == '0)), "reset did not clear window")

endmodule

// File: rtl/byte_pattern_find_replace_core.sv
// Top level of the byte pattern find/replace core: input register, match
// window, result register and APB config. Depends on bpfr_pkg, bpfr_cfg and
// bpfr_window.
//
//   channel  direction  handshake                   payload
//   in       sink       i_in_valid / o_in_stall     i_in_data  (t_in_item)
//   out      source     o_out_valid / i_out_stall   o_out_data (t_out_item)
//   cfg      APB slave  psel penable pwrite pready  paddr pwdata prdata
//
// One byte a cycle in steady state while the output is not stalled. A request
// waits in the input register until the window takes it. A flushing request,
// or one taken after the pattern length was lowered, keeps the window draining
// its held bytes (one byte out a cycle while the output is not stalled),
// stalling the next request until the drain ends. Synchronous active-low reset
// empties the window and clears the valid flags and config registers. Stall on
// the output backs up through the input register within the same cycle.
`timescale 1ns / 1ps

module byte_pattern_find_replace_core import bpfr_pkg::*; #(
    parameter int MAX_PATTERN = BPFR_MAX_PATTERN
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output t_out_item              o_out_data,
    input  logic                   i_out_stall,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [BPFR_ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      item_take;
    logic      res_ready;
    logic      res_valid;
    t_out_item res;

    bpfr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register: refills whenever empty or consumed
    assign o_in_stall = r_in_valid && !item_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) r_in <= i_in_data;
    end

    bpfr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (r_in_valid),
        .i_item       (r_in),
        .i_res_ready  (res_ready),
        .o_item_take  (item_take),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Result register
    assign res_ready   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) r_out <= res;
    end

endmodule
